// ===== rtl/vdr_pkg.sv =====
// shared constants for the vertex deduplication and remap block
package vdr_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned MAX_WORDS_DEF    = 64;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT = 24;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_START  = 2'd3;

  localparam int unsigned NUM_W = 11;

endpackage

// ===== rtl/vdr_ram.sv =====
// generic single-port ram with registered read
module vdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/vdr_mix_mul.sv =====
// shared multiply by the hash mix constant, low 32 bits
module vdr_mix_mul
  import vdr_pkg::*;
(
  input  logic [31:0] a,
  output logic [31:0] prod
);

  logic [63:0] full;

  assign full = a * MIX_MUL;
  assign prod = full[31:0];

endmodule

// ===== rtl/vertex_dedup_remap.sv =====
// vertex dedup remap top level: hash sequencer, probe loop, tables and ports
// a load writes the vertex store, a finish emits the count, a mapped index emits its number
// an index not yet mapped hashes its W whole words, then probes the bucket table; each probe
// that misses may compare up to C words (W whole words hashed, C words compared)
// throughput: one item at a time; s_axis_tready is high only while the sequencer idles
// reset and start items run a clearing pass over every entry of both tables
module vertex_dedup_remap
  import vdr_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_WORDS    = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // vertex_id[9:0], word_pos[15:10], data_word[47:16]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // source_vertex[9:0], value[20:10], zero[23:21]
  output logic        m_axis_tuser,  // is_count[0]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned STORE_DEPTH = MAX_VERTICES << WW;

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_SIZE  = 1'b1;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLEAR    = 5'd1;
  localparam logic [4:0] S_RMAP_RD  = 5'd2;
  localparam logic [4:0] S_RMAP_CHK = 5'd3;
  localparam logic [4:0] S_H_RD     = 5'd4;
  localparam logic [4:0] S_H_K1     = 5'd5;
  localparam logic [4:0] S_H_K2     = 5'd6;
  localparam logic [4:0] S_H_H      = 5'd7;
  localparam logic [4:0] S_P_INIT   = 5'd8;
  localparam logic [4:0] S_B_RD     = 5'd9;
  localparam logic [4:0] S_B_CHK    = 5'd10;
  localparam logic [4:0] S_O_RD     = 5'd11;
  localparam logic [4:0] S_O_CHK    = 5'd12;
  localparam logic [4:0] S_C_RDA    = 5'd13;
  localparam logic [4:0] S_C_RDB    = 5'd14;
  localparam logic [4:0] S_C_CMP    = 5'd15;
  localparam logic [4:0] S_NEXT     = 5'd16;
  localparam logic [4:0] S_ASSIGN   = 5'd17;
  localparam logic [4:0] S_EMIT     = 5'd18;

  // input fields
  logic [9:0]  in_vid;
  logic [5:0]  in_pos;
  logic [31:0] in_data;
  logic [1:0]  in_kind;
  assign in_vid  = s_axis_tdata[9:0];
  assign in_pos  = s_axis_tdata[15:10];
  assign in_data = s_axis_tdata[47:16];
  assign in_kind = s_axis_tuser;

  // configuration registers
  logic [10:0] count_reg;
  logic [8:0]  size_reg;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= 11'd1024;
      size_reg  <= 9'd16;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COUNT: count_reg <= pwdata[10:0];
        REG_SIZE:  size_reg  <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNT: prdata = {21'd0, count_reg};
      REG_SIZE:  prdata = {23'd0, size_reg};
      default:   prdata = 32'd0;
    endcase
  end

  // derived figures, registered; config must only change while idle, the block does not enforce it
  logic [VW-1:0] mod;
  logic [CW-1:0] words;
  logic [CW-1:0] cmp_words;
  logic [1:0]    rest;
  logic [31:0]   c32;
  logic [8:0]    s_use;
  logic [VW-1:0] cm1;
  logic [VW-1:0] mod_c;

  always_comb begin
    c32 = {21'd0, count_reg};
    if (c32 == 32'd0) begin
      c32 = 32'd1;
    end else if (c32 > 32'(MAX_VERTICES)) begin
      c32 = 32'(MAX_VERTICES);
    end
    cm1 = VW'(c32 - 32'd1);
    // smallest power of two at or above the count, minus one
    for (int i = 0; i < VW; i++) begin
      mod_c[i] = |(cm1 >> i);
    end
    s_use = size_reg;
    if (s_use == 9'd0) begin
      s_use = 9'd1;
    end else if (32'(s_use) > 32'(4 * MAX_WORDS)) begin
      s_use = 9'(4 * MAX_WORDS);
    end
  end

  always_ff @(posedge clk) begin
    mod       <= mod_c;
    words     <= CW'(s_use >> 2);
    rest      <= s_use[1:0];
    cmp_words <= CW'(s_use >> 2) + CW'(s_use[1:0] != 2'd0);
  end

  // sequencer registers
  logic [4:0]       state;
  logic [VW-1:0]    clr_addr;
  logic [9:0]       vid_in;
  logic [CW-1:0]    w;
  logic [31:0]      h;
  logic [31:0]      kreg;
  logic [VW-1:0]    b;
  logic [VW-1:0]    probe;
  logic [VW-1:0]    other;
  logic [NUM_W-1:0] next_number;
  logic [NUM_W-1:0] res_val;
  logic [NUM_W-1:0] oval;
  logic             res_cnt;
  logic [31:0]      areg;

  logic [VW-1:0] vid_v;
  assign vid_v = VW'(vid_in);

  // memories
  logic                    st_we;
  logic [$clog2(STORE_DEPTH)-1:0] st_addr;
  logic [31:0]             st_rdata;
  logic                    rm_we;
  logic [VW-1:0]           rm_addr;
  logic [NUM_W:0]          rm_wdata;
  logic [NUM_W:0]          rm_rdata;
  logic                    bk_we;
  logic [VW-1:0]           bk_addr;
  logic [VW:0]             bk_wdata;
  logic [VW:0]             bk_rdata;

  logic accept;
  logic load_ok;
  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign load_ok = (32'(in_vid) < 32'(MAX_VERTICES)) && (32'(in_pos) < 32'(MAX_WORDS));

  // vertex store: load writes, hash and compare reads
  always_comb begin
    st_we   = 1'b0;
    st_addr = {VW'(in_vid), WW'(in_pos)};
    case (state)
      S_IDLE: st_we = accept && (in_kind == KIND_LOAD) && load_ok;
      S_H_RD, S_H_K1, S_C_RDA: st_addr = {vid_v, w[WW-1:0]};
      S_C_RDB: st_addr = {other, w[WW-1:0]};
      default: ;
    endcase
  end

  // remap table: valid bit over the compact number
  always_comb begin
    rm_we    = 1'b0;
    rm_addr  = vid_v;
    rm_wdata = {1'b1, res_val};
    case (state)
      S_CLEAR: begin
        rm_we    = 1'b1;
        rm_addr  = clr_addr;
        rm_wdata = '0;
      end
      S_ASSIGN: rm_we = 1'b1;
      S_O_RD, S_O_CHK: rm_addr = other;
      default: ;
    endcase
  end

  // bucket table: valid bit over the owning vertex
  always_comb begin
    bk_we    = 1'b0;
    bk_addr  = b;
    bk_wdata = {1'b1, vid_v};
    case (state)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_addr  = clr_addr;
        bk_wdata = '0;
      end
      S_B_CHK: bk_we = ~bk_rdata[VW];
      default: ;
    endcase
  end

  vdr_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(in_data), .rdata(st_rdata)
  );

  vdr_ram #(.WIDTH(NUM_W + 1), .DEPTH(1 << VW)) u_remap (
    .clk(clk), .we(rm_we), .addr(rm_addr), .wdata(rm_wdata), .rdata(rm_rdata)
  );

  vdr_ram #(.WIDTH(VW + 1), .DEPTH(1 << VW)) u_bucket (
    .clk(clk), .we(bk_we), .addr(bk_addr), .wdata(bk_wdata), .rdata(bk_rdata)
  );

  // shared mix multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_p;

  always_comb begin
    case (state)
      S_H_K1:  mul_a = st_rdata;
      S_H_K2:  mul_a = kreg ^ (kreg >> MIX_SHIFT);
      default: mul_a = h;
    endcase
  end

  vdr_mix_mul u_mul (.a(mul_a), .prod(mul_p));

  // byte mask for the trailing partial word
  logic [31:0] cmp_mask;
  always_comb begin
    cmp_mask = 32'hffff_ffff;
    if (w == words) begin
      case (rest)
        2'd1:    cmp_mask = 32'h0000_00ff;
        2'd2:    cmp_mask = 32'h0000_ffff;
        2'd3:    cmp_mask = 32'h00ff_ffff;
        default: cmp_mask = 32'hffff_ffff;
      endcase
    end
  end

  logic [VW:0] b_step;
  assign b_step = (VW + 1)'(b) + (VW + 1)'(probe) + (VW + 1)'(1);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      next_number   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a result taken while the next one is being loaded stays valid
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_kind)
              KIND_INDEX: begin
                vid_in <= in_vid;
                if (32'(in_vid) < c32) begin
                  state <= S_RMAP_RD;
                end
              end
              KIND_FINISH: begin
                res_cnt <= 1'b1;
                res_val <= next_number;
                vid_in  <= '0;
                state   <= S_EMIT;
              end
              KIND_START: begin
                next_number <= '0;
                clr_addr    <= '0;
                state       <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + VW'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_RMAP_RD: state <= S_RMAP_CHK;
        S_RMAP_CHK: begin
          res_cnt <= 1'b0;
          if (rm_rdata[NUM_W]) begin
            res_val <= rm_rdata[NUM_W-1:0];
            state   <= S_EMIT;
          end else begin
            h     <= '0;
            w     <= '0;
            state <= (words == '0) ? S_P_INIT : S_H_RD;
          end
        end
        S_H_RD: state <= S_H_K1;
        S_H_K1: begin
          kreg  <= mul_p;
          state <= S_H_K2;
        end
        S_H_K2: begin
          kreg  <= mul_p;
          state <= S_H_H;
        end
        S_H_H: begin
          h     <= mul_p ^ kreg;
          w     <= w + CW'(1);
          state <= (w + CW'(1) == words) ? S_P_INIT : S_H_RD;
        end
        S_P_INIT: begin
          b     <= VW'(h) & mod;
          probe <= '0;
          state <= S_B_RD;
        end
        S_B_RD: state <= S_B_CHK;
        S_B_CHK: begin
          if (!bk_rdata[VW]) begin
            res_val     <= next_number;
            next_number <= next_number + NUM_W'(1);
            state       <= S_ASSIGN;
          end else begin
            other <= bk_rdata[VW-1:0];
            state <= S_O_RD;
          end
        end
        S_O_RD: state <= S_O_CHK;
        S_O_CHK: begin
          if (rm_rdata[NUM_W]) begin
            oval  <= rm_rdata[NUM_W-1:0];
            w     <= '0;
            state <= S_C_RDA;
          end else begin
            state <= S_NEXT;
          end
        end
        S_C_RDA: state <= S_C_RDB;
        S_C_RDB: begin
          areg  <= st_rdata;
          state <= S_C_CMP;
        end
        S_C_CMP: begin
          if (((areg ^ st_rdata) & cmp_mask) != 32'd0) begin
            state <= S_NEXT;
          end else if (w + CW'(1) == cmp_words) begin
            res_val <= oval;
            state   <= S_ASSIGN;
          end else begin
            w     <= w + CW'(1);
            state <= S_C_RDA;
          end
        end
        S_NEXT: begin
          if (probe == mod) begin
            // table full: number given but not entered
            res_val     <= next_number;
            next_number <= next_number + NUM_W'(1);
            state       <= S_ASSIGN;
          end else begin
            b     <= VW'(b_step) & mod;
            probe <= probe + VW'(1);
            state <= S_B_RD;
          end
        end
        S_ASSIGN: state <= S_EMIT;
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'd0, res_val, vid_in};
            m_axis_tuser  <= res_cnt;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/vertex_dedup_remap_tb.sv =====
// testbench for the vertex deduplication and remap block
module vertex_dedup_remap_tb;
  import vdr_pkg::*;

  localparam int unsigned NV = MAX_VERTICES_DEF;
  localparam int unsigned NW = MAX_WORDS_DEF;
  // register byte addresses
  localparam logic [2:0] ADDR_COUNT = 3'd0;
  localparam logic [2:0] ADDR_SIZE  = 3'd4;
  // clearing pass plus slack, used before a register write
  localparam int unsigned SETTLE    = NV + 64;
  localparam longint unsigned LIMIT = 2000000;

  typedef struct packed {
    logic       is_count;
    logic [9:0] src;
    logic [10:0] num;
  } remap_ans_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // vertex_id[9:0], word_pos[15:10], data_word[47:16]
  logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // source_vertex[9:0], value[20:10], zero[23:21]
  logic        m_axis_tuser;       // is_count[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vertex_dedup_remap dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // mirror of the block state
  logic [31:0] vstore [NV][NW];
  bit          loaded [NV][NW];      // words the bench has written, never read otherwise
  bit          mapped [NV];
  int unsigned map_num [NV];
  bit          bkt_used [NV];
  int unsigned bkt_vtx [NV];
  int unsigned next_num;
  logic [10:0] reg_count = 11'd1024;
  logic [8:0]  reg_size = 9'd16;

  remap_ans_t  pending_ans[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned count_eff();
    if (reg_count == 0) return 1;
    if (reg_count > NV) return NV;
    return reg_count;
  endfunction

  function automatic int unsigned size_eff();
    if (reg_size == 0) return 1;
    if (reg_size > 4 * NW) return 4 * NW;
    return reg_size;
  endfunction

  // words touched by a lookup, partial word included
  function automatic int unsigned words_needed();
    return (size_eff() + 3) / 4;
  endfunction

  function automatic logic [31:0] mix_word(logic [31:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    return k * MIX_MUL;
  endfunction

  function automatic logic [31:0] vertex_hash(int unsigned v);
    logic [31:0] h = '0;
    for (int w = 0; w < size_eff() / 4; w++) h = (h * MIX_MUL) ^ mix_word(vstore[v][w]);
    return h;
  endfunction

  function automatic bit vertex_equal(int unsigned a, int unsigned b);
    int unsigned whole = size_eff() / 4;
    int unsigned rest = size_eff() % 4;
    logic [31:0] mask;
    for (int w = 0; w < whole; w++) if (vstore[a][w] != vstore[b][w]) return 0;
    if (rest != 0) begin
      mask = (32'd1 << (rest * 8)) - 1;
      if ((vstore[a][whole] & mask) != (vstore[b][whole] & mask)) return 0;
    end
    return 1;
  endfunction

  function automatic int unsigned assign_number(int unsigned v);
    int unsigned nb = 1;
    int unsigned mask, b, other;
    while (nb < count_eff()) nb = nb * 2;
    mask = nb - 1;
    b = vertex_hash(v) & mask;
    for (int unsigned p = 0; p <= mask; p++) begin
      if (!bkt_used[b]) begin
        bkt_used[b] = 1;
        bkt_vtx[b] = v;
        return next_num++;
      end
      other = bkt_vtx[b];
      if (vertex_equal(other, v) && mapped[other]) return map_num[other];
      b = (b + p + 1) & mask;
    end
    // table full: numbered but not entered
    return next_num++;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < NV; i++) begin
      mapped[i] = 0;
      map_num[i] = 0;
      bkt_used[i] = 0;
      bkt_vtx[i] = 0;
    end
    next_num = 0;
  endfunction

  function automatic void predict_item(logic [1:0] kind, int unsigned vid, int unsigned pos,
                                       logic [31:0] data);
    remap_ans_t a;
    case (kind)
      KIND_LOAD: begin
        vstore[vid][pos] = data;
        loaded[vid][pos] = 1;
      end
      KIND_INDEX: begin
        if (vid < count_eff()) begin
          if (!mapped[vid]) begin
            map_num[vid] = assign_number(vid);
            mapped[vid] = 1;
          end
          a.is_count = 1'b0;
          a.src = vid;
          a.num = map_num[vid][10:0];
          pending_ans.push_back(a);
        end
      end
      KIND_FINISH: begin
        a.is_count = 1'b1;
        a.src = '0;
        a.num = next_num[10:0];
        pending_ans.push_back(a);
      end
      default: clear_tables();
    endcase
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // sends one item; inputs move at the falling edge, acceptance seen at the rising edge
  task automatic send_item(logic [1:0] kind, int unsigned vid, int unsigned pos,
                           logic [31:0] data);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {data, pos[5:0], vid[9:0]};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(kind, vid, pos, data);
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_ans.size() != 0) @(posedge clk);
  endtask

  // register writes only once the block has gone idle
  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = val; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_COUNT) reg_count = val[10:0];
    else reg_size = val[8:0];
  endtask

  task automatic set_config(int unsigned cnt, int unsigned sz);
    write_reg(ADDR_COUNT, cnt);
    write_reg(ADDR_SIZE, sz);
  endtask

  // loads any word a lookup of v would read; content from a small pool to make duplicates
  task automatic fill_vertex(int unsigned v);
    for (int w = 0; w < words_needed(); w++)
      if (!loaded[v][w]) send_item(KIND_LOAD, v, w, $urandom_range(3));
  endtask

  task automatic send_index(int unsigned v);
    if (v < count_eff()) fill_vertex(v);
    send_item(KIND_INDEX, v, 0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    remap_ans_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_ans.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        want = pending_ans.pop_front();
        if (m_axis_tuser !== want.is_count) report("is_count", m_axis_tuser, want.is_count);
        if (m_axis_tdata[9:0] !== want.src) report("source_vertex", m_axis_tdata[9:0], want.src);
        if (m_axis_tdata[20:10] !== want.num) report("value", m_axis_tdata[20:10], want.num);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // reset values, duplicates by content, repeated lookups and the count
  task automatic test_reset_config();
    for (int v = 0; v < 4; v++)
      for (int w = 0; w < 4; w++) send_item(KIND_LOAD, v, w, (v == 2) ? w : v * 16 + w);
    send_index(0); send_index(1); send_index(2); send_index(3); send_index(2);
    send_item(KIND_FINISH, 0, 0, '0);
  endtask

  // largest count and size, all-ones and all-zero words, every vertex bit
  task automatic test_extremes();
    set_config(11'h7FF, 9'h1FF);
    send_item(KIND_START, 0, 0, '0);
    for (int w = 0; w < NW; w++) begin
      send_item(KIND_LOAD, 1023, w, w[0] ? 32'hFFFF_FFFF : 32'h0);
      send_item(KIND_LOAD, 512, w, w[0] ? 32'hFFFF_FFFF : 32'h0);
      send_item(KIND_LOAD, 0, w, (w == NW - 1) ? 32'h8000_0000 : (w[0] ? 32'hFFFF_FFFF : 32'h0));
    end
    send_index(1023); send_index(512); send_index(0);
    send_item(KIND_FINISH, 0, 0, '0);
    // zero registers act as one
    set_config(0, 0);
    send_item(KIND_START, 0, 0, '0);
    send_index(0);
    send_index(1);      // out of range, no answer
    send_index(1023);
    send_item(KIND_FINISH, 0, 0, '0);
  endtask

  // trailing partial word is compared bytewise but not hashed
  task automatic test_partial_word();
    set_config(4, 6);
    send_item(KIND_START, 0, 0, '0);
    send_item(KIND_LOAD, 1, 0, 32'hDEAD_BEEF);
    send_item(KIND_LOAD, 2, 0, 32'hDEAD_BEEF);
    send_item(KIND_LOAD, 1, 1, 32'h0011_2233);
    send_item(KIND_LOAD, 2, 1, 32'h5544_2233);
    send_index(1); send_index(2); send_index(3);
    // loading after use keeps the number
    send_item(KIND_LOAD, 1, 0, 32'h1);
    send_index(1);
    send_item(KIND_FINISH, 0, 0, '0);
  endtask

  // fill buckets 0 and 1, then shrink the count to two so a new vertex finds no room
  task automatic test_full_table();
    logic [31:0] d;
    set_config(4, 4);
    send_item(KIND_START, 0, 0, '0);
    for (int v = 2; v < 4; v++) begin
      do d = $urandom(); while ((mix_word(d) & 3) != v - 2);
      send_item(KIND_LOAD, v, 0, d);
      send_index(v);
    end
    send_item(KIND_LOAD, 0, 0, 32'h1234_5678);
    write_reg(ADDR_COUNT, 2);
    send_index(0);
    send_index(0);
    send_item(KIND_FINISH, 0, 0, '0);
  endtask

  // random phase: lookups and loads over a few vertices with small contents
  task automatic test_random(int n, int gap, int stall, bit keep_tables);
    int unsigned v, sel;
    gap_pct = gap;
    stall_pct = stall;
    if (keep_tables) begin
      // set a new small count without clearing, size unchanged
      write_reg(ADDR_COUNT, $urandom_range(1, 8));
    end else begin
      set_config($urandom_range(0, 9) == 0 ? $urandom_range(33, 300) : $urandom_range(1, 32),
                 $urandom_range(0, 9) == 0 ? $urandom_range(33, 96) : $urandom_range(1, 32));
      send_item(KIND_START, 0, 0, '0);
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      v = $urandom_range(count_eff() - 1);
      if (sel < 50) begin
        send_index($urandom_range(19) == 0 ? $urandom_range(1023) : v);
      end else if (sel < 88) begin
        send_item(KIND_LOAD, v, $urandom_range(words_needed() - 1),
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(3));
      end else if (sel < 93) begin
        send_item(KIND_LOAD, $urandom_range(1023), $urandom_range(63), $urandom());
      end else if (sel < 97) begin
        send_item(KIND_FINISH, 0, 0, '0);
      end else if (sel < 98) begin
        send_item(KIND_START, 0, 0, '0);
      end else begin
        wait_drained();
      end
    end
    send_item(KIND_FINISH, 0, 0, '0);
  endtask

  initial begin
    for (int i = 0; i < NV; i++) for (int w = 0; w < NW; w++) begin
      vstore[i][w] = '0;
      loaded[i][w] = 0;
    end
    clear_tables();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_extremes();
    test_partial_word();
    test_full_table();
    test_random(150, 0, 0, 0);
    test_random(150, 67, 0, 0);
    test_random(60, 0, 67, 1);
    test_random(120, 0, 67, 0);
    test_random(150, 23, 23, 0);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d items, checked %0d results", n_items, n_results);
    $display("covered directed extremes, partial words, full table and five random phases");
    if (errors == 0 && pending_ans.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
